// ===== rtl/core/fspc_pkg.sv =====
// Package for the five-stage pipeline core: memory sizes, opcodes, modes,
// sequencer states, pipeline stage types and shared helper functions.
package fspc_pkg;

  localparam int IMEM_BYTES = 1024;
  localparam int DMEM_BYTES = 1024;
  localparam int IMEM_AW = $clog2(IMEM_BYTES);
  localparam int DMEM_AW = $clog2(DMEM_BYTES);
  localparam int CLR_AW = (IMEM_AW > DMEM_AW) ? IMEM_AW : DMEM_AW;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW = 5;

  localparam logic [2:0] MODE_LOAD_INSTR = 3'd0;
  localparam logic [2:0] MODE_LOAD_DATA  = 3'd1;
  localparam logic [2:0] MODE_RUN        = 3'd2;
  localparam logic [2:0] MODE_READ_REG   = 3'd3;
  localparam logic [2:0] MODE_READ_WORD  = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_BNE   = 6'h04;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RREG, ST_DWORD, ST_WB, ST_MEM_RD, ST_MEM_WR,
    ST_ID_RS, ST_ID_RT, ST_ID_CAP, ST_IF, ST_COMMIT
  } seq_state_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        nop;
  } fetch_t;

  typedef struct packed {
    logic [31:0] instr;
    logic        nop;
  } dec_t;

  typedef struct packed {
    logic [31:0] rd1;
    logic [31:0] rd2;
    logic [15:0] imm;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  wreg;
    logic        is_i;
    logic        rd_mem;
    logic        wrt_mem;
    logic        alu_add;
    logic        wen;
    logic        nop;
  } exe_t;

  typedef struct packed {
    logic [31:0] alu;
    logic [31:0] store;
    logic [4:0]  rt;
    logic [4:0]  wreg;
    logic        rd_mem;
    logic        wrt_mem;
    logic        wen;
    logic        nop;
  } mem_t;

  typedef struct packed {
    logic [31:0] data;
    logic [4:0]  wreg;
    logic        wen;
    logic        nop;
  } wb_t;

  typedef struct packed {
    logic [31:0] memw;
    logic [31:0] rd1;
    logic [31:0] rd2;
    logic [31:0] insw;
  } reads_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] fwd_store_word(input mem_t m, input wb_t w);
    return (!w.nop && w.wen && w.wreg == m.rt) ? w.data : m.store;
  endfunction

endpackage

// ===== rtl/core/fspc_if.sv =====
// Valid/ready channel interfaces for the core's command and response sides.
// Depends on nothing.
interface fspc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [9:0]  address;
  logic [7:0]  byte_value;
  modport source (output valid, mode, address, byte_value, input ready);
  modport sink (input valid, mode, address, byte_value, output ready);
endinterface

interface fspc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [31:0] fetch_address;
  logic        finished;
  logic        stalled;
  modport source (output valid, read_value, fetch_address, finished, stalled, input ready);
  modport sink (input valid, read_value, fetch_address, finished, stalled, output ready);
endinterface

// ===== rtl/core/fspc_ram.sv =====
// Generic synchronous RAM, one write and one read port, registered read data.
// Depends on nothing.
module fspc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/fspc_stage_logic.sv =====
// Next-state logic of the five pipeline stages: ALU, forwarding, decode,
// branch, load-use interlock and fetch. Depends on fspc_pkg.
module fspc_stage_logic import fspc_pkg::*; (
  input  fetch_t f,
  input  dec_t   d,
  input  exe_t   e,
  input  mem_t   m,
  input  wb_t    w,
  input  reads_t rd,
  output fetch_t nf,
  output dec_t   nd,
  output exe_t   ne,
  output mem_t   nm,
  output wb_t    nw,
  output logic   stall,
  output logic   fin
);
  logic [31:0] a, b, sd;
  logic        rtype_w, id_bubble, if_idle;
  logic [5:0]  op;
  logic [4:0]  rs, rt;

  always_comb begin
    sd = fwd_store_word(m, w);
    nw = w;
    if (!m.nop) begin
      if (m.rd_mem) begin
        nw.data = rd.memw;
      end else if (m.wrt_mem) begin
        nw.data = sd;
      end else if (m.wen) begin
        nw.data = m.alu;
      end
      nw.wreg = m.wreg;
      nw.wen = m.wen;
    end
    nw.nop = m.nop;

    a = e.rd1;
    b = e.rd2;
    rtype_w = !e.is_i && e.wen;
    if (!w.nop && w.wen && w.wreg == e.rs) a = w.data;
    if (!w.nop && w.wen && w.wreg == e.rt && (rtype_w || e.wrt_mem)) b = w.data;
    if (!m.nop && m.wen && m.wreg == e.rs) a = m.alu;
    if (!m.nop && m.wen && m.wreg == e.rt && rtype_w) b = m.alu;
    nm = m;
    if (!e.nop) begin
      if (!e.is_i) begin
        nm.alu = e.wen ? (e.alu_add ? a + b : a - b) : 32'd0;
      end else begin
        nm.alu = a + sext16(e.imm);
      end
      nm.store = b;
      nm.rt = e.rt;
      nm.wreg = e.wreg;
      nm.rd_mem = e.rd_mem;
      nm.wrt_mem = e.wrt_mem;
      nm.wen = e.wen;
    end
    nm.nop = e.nop;

    nf = f;
    nd = d;
    ne = e;
    stall = 1'b0;
    fin = 1'b0;
    op = d.instr[31:26];
    rs = d.instr[25:21];
    rt = d.instr[20:16];
    id_bubble = d.nop;
    if_idle = f.nop;
    if (!d.nop) begin
      ne.rs = rs;
      ne.rt = rt;
      ne.rd1 = rd.rd1;
      ne.rd2 = rd.rd2;
      ne.imm = d.instr[15:0];
      case (op)
        OP_RTYPE: begin
          ne.wreg = d.instr[15:11];
          ne.is_i = 1'b0;
          ne.rd_mem = 1'b0;
          ne.wrt_mem = 1'b0;
          if (d.instr[5:0] == FN_ADDU) ne.alu_add = 1'b1;
          else if (d.instr[5:0] == FN_SUBU) ne.alu_add = 1'b0;
          ne.wen = 1'b1;
        end
        OP_LW: begin
          ne.wreg = rt;
          ne.is_i = 1'b1;
          ne.rd_mem = 1'b1;
          ne.wrt_mem = 1'b0;
          ne.alu_add = 1'b1;
          ne.wen = 1'b1;
        end
        OP_SW: begin
          ne.wreg = rt;
          ne.is_i = 1'b1;
          ne.rd_mem = 1'b0;
          ne.wrt_mem = 1'b1;
          ne.alu_add = 1'b1;
          ne.wen = 1'b0;
        end
        OP_BNE: begin
          ne.wreg = 5'd0;
          ne.is_i = 1'b0;
          ne.rd_mem = 1'b0;
          ne.wrt_mem = 1'b0;
          ne.alu_add = 1'b1;
          ne.wen = 1'b0;
        end
        default: id_bubble = 1'b1;
      endcase
    end

    if (!d.nop && op == OP_BNE && rd.rd1 != rd.rd2) begin
      // taken branch: redirect fetch, drop decode
      nf.pc = f.pc + {{14{d.instr[15]}}, d.instr[15:0], 2'b00};
      nf.nop = 1'b0;
      nd.nop = 1'b1;
      ne.nop = 1'b0;
    end else if (!d.nop && op == OP_RTYPE && !e.nop && e.rd_mem &&
                 (e.wreg == rs || e.wreg == rt)) begin
      // load-use: hold fetch and decode
      ne.nop = 1'b1;
      stall = 1'b1;
      nf = f;
      nd = d;
    end else begin
      ne.nop = id_bubble;
      if (!f.nop) begin
        nd.instr = rd.insw;
        if (rd.insw != HALT_WORD) begin
          nf.pc = f.pc + 32'd4;
          nf.nop = 1'b0;
        end else begin
          nf.nop = 1'b1;
          if_idle = 1'b1;
        end
      end
      nd.nop = if_idle;
      fin = if_idle && d.nop && e.nop && m.nop && w.nop;
    end
  end
endmodule

// ===== rtl/core/five_stage_pipeline_core.sv =====
// Five-stage pipeline core (addu, subu, lw, sw, bne) with byte memories and
// register file in synchronous RAMs. Depends on fspc_pkg, fspc_if, fspc_ram,
// fspc_stage_logic.
//
// After reset the core zeroes instruction memory, data memory and the
// register file, and accepts no transaction meanwhile. Items are handled
// one at a time; a result waits in an output register. A run item steps
// through writeback, a load or store memory state, decode register reads,
// fetch when fetch is active, and commit; memory accesses go byte by byte,
// as the byte-wide memories deliver one byte per cycle.
module five_stage_pipeline_core import fspc_pkg::*; (
  input logic clk,
  input logic rst,
  fspc_cmd_if.sink   cmd,
  fspc_rsp_if.source rsp
);
  seq_state_t state, state_next;
  logic [CLR_AW-1:0] clr;
  logic [2:0]  cnt;
  logic [9:0]  addr_q;
  logic [23:0] acc;
  logic [31:0] word_in;
  logic        accept;

  fetch_t f, nf;
  dec_t   d, nd;
  exe_t   e, ne;
  mem_t   m, nm;
  wb_t    w, nw;
  reads_t rd;
  logic   stall, fin, allnop;
  logic [31:0] sd;

  logic                imem_we, dmem_we, rf_we;
  logic [IMEM_AW-1:0]  imem_waddr, imem_raddr;
  logic [DMEM_AW-1:0]  dmem_waddr, dmem_raddr;
  logic [RF_AW-1:0]    rf_waddr, rf_raddr;
  logic [7:0]          imem_wdata, dmem_wdata, imem_rdata, dmem_rdata;
  logic [31:0]         rf_wdata, rf_rdata, dbase;

  function automatic logic [7:0] rdata_sel(input seq_state_t s, input logic [7:0] ib,
                                           input logic [7:0] db);
    return (s == ST_IF) ? ib : db;
  endfunction

  fspc_ram #(.DEPTH(IMEM_BYTES), .WIDTH(8)) u_imem (
    .clk(clk), .we(imem_we), .waddr(imem_waddr), .wdata(imem_wdata),
    .raddr(imem_raddr), .rdata(imem_rdata));
  fspc_ram #(.DEPTH(DMEM_BYTES), .WIDTH(8)) u_dmem (
    .clk(clk), .we(dmem_we), .waddr(dmem_waddr), .wdata(dmem_wdata),
    .raddr(dmem_raddr), .rdata(dmem_rdata));
  fspc_ram #(.DEPTH(RF_DEPTH), .WIDTH(32)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata));

  fspc_stage_logic u_stage (
    .f(f), .d(d), .e(e), .m(m), .w(w), .rd(rd),
    .nf(nf), .nd(nd), .ne(ne), .nm(nm), .nw(nw), .stall(stall), .fin(fin));

  assign cmd.ready = (state == ST_IDLE) && !rsp.valid;
  assign accept = cmd.valid && cmd.ready;
  assign allnop = f.nop && d.nop && e.nop && m.nop && w.nop;
  assign word_in = {acc, rdata_sel(state, imem_rdata, dmem_rdata)};
  assign sd = fwd_store_word(m, w);
  assign dbase = (state == ST_DWORD) ? {22'd0, addr_q} : m.alu;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (&clr) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            MODE_RUN:       state_next = ST_WB;
            MODE_READ_REG:  state_next = ST_RREG;
            MODE_READ_WORD: state_next = ST_DWORD;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_RREG:   state_next = ST_IDLE;
      ST_DWORD:  if (cnt == 3'd4) state_next = ST_IDLE;
      ST_WB: begin
        if (!m.nop && m.rd_mem) state_next = ST_MEM_RD;
        else if (!m.nop && m.wrt_mem) state_next = ST_MEM_WR;
        else state_next = ST_ID_RS;
      end
      ST_MEM_RD: if (cnt == 3'd4) state_next = ST_ID_RS;
      ST_MEM_WR: if (cnt == 3'd3) state_next = ST_ID_RS;
      ST_ID_RS:  state_next = ST_ID_RT;
      ST_ID_RT:  state_next = ST_ID_CAP;
      ST_ID_CAP: state_next = f.nop ? ST_COMMIT : ST_IF;
      ST_IF:     if (cnt == 3'd4) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    imem_we = 1'b0;
    imem_waddr = IMEM_AW'(cmd.address);
    imem_wdata = cmd.byte_value;
    imem_raddr = IMEM_AW'(f.pc + 32'(cnt));
    dmem_we = 1'b0;
    dmem_waddr = DMEM_AW'(cmd.address);
    dmem_wdata = cmd.byte_value;
    dmem_raddr = DMEM_AW'(dbase + 32'(cnt));
    rf_we = 1'b0;
    rf_waddr = w.wreg;
    rf_wdata = w.data;
    rf_raddr = cmd.address[RF_AW-1:0];
    case (state)
      ST_CLEAR: begin
        imem_we = 1'b1;
        imem_waddr = clr[IMEM_AW-1:0];
        imem_wdata = 8'd0;
        dmem_we = 1'b1;
        dmem_waddr = clr[DMEM_AW-1:0];
        dmem_wdata = 8'd0;
        rf_we = 1'b1;
        rf_waddr = clr[RF_AW-1:0];
        rf_wdata = 32'd0;
      end
      ST_IDLE: begin
        imem_we = accept && cmd.mode == MODE_LOAD_INSTR;
        dmem_we = accept && cmd.mode == MODE_LOAD_DATA;
      end
      ST_WB: rf_we = !w.nop && w.wen;
      ST_MEM_WR: begin
        dmem_we = 1'b1;
        dmem_waddr = DMEM_AW'(m.alu + 32'(cnt));
        dmem_wdata = 8'(sd >> (5'd24 - {cnt[1:0], 3'b000}));
      end
      ST_ID_RS: rf_raddr = d.instr[25:21];
      ST_ID_RT: rf_raddr = d.instr[20:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      cnt <= 3'd0;
      rsp.valid <= 1'b0;
      f <= '{pc: 32'd0, nop: 1'b0};
      d <= '{instr: 32'd0, nop: 1'b1};
      e <= '{nop: 1'b1, default: '0};
      m <= '{nop: 1'b1, default: '0};
      w <= '{nop: 1'b1, default: '0};
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (state != state_next) cnt <= 3'd0;
      else cnt <= cnt + 3'd1;
      if (state == ST_DWORD || state == ST_MEM_RD || state == ST_IF) begin
        acc <= word_in[23:0];
      end
      case (state)
        ST_IDLE: begin
          addr_q <= cmd.address;
          if (accept && cmd.mode != MODE_RUN && cmd.mode != MODE_READ_REG &&
              cmd.mode != MODE_READ_WORD) begin
            rsp.valid <= 1'b1;
            rsp.read_value <= 32'd0;
            rsp.fetch_address <= f.pc;
            rsp.finished <= allnop;
            rsp.stalled <= 1'b0;
          end
        end
        ST_RREG: begin
          rsp.valid <= 1'b1;
          rsp.read_value <= rf_rdata;
          rsp.fetch_address <= f.pc;
          rsp.finished <= allnop;
          rsp.stalled <= 1'b0;
        end
        ST_DWORD: begin
          if (cnt == 3'd4) begin
            rsp.valid <= 1'b1;
            rsp.read_value <= word_in;
            rsp.fetch_address <= f.pc;
            rsp.finished <= allnop;
            rsp.stalled <= 1'b0;
          end
        end
        ST_MEM_RD: if (cnt == 3'd4) rd.memw <= word_in;
        ST_ID_RT:  rd.rd1 <= rf_rdata;
        ST_ID_CAP: rd.rd2 <= rf_rdata;
        ST_IF:     if (cnt == 3'd4) rd.insw <= word_in;
        ST_COMMIT: begin
          f <= nf;
          d <= nd;
          e <= ne;
          m <= nm;
          w <= nw;
          rsp.valid <= 1'b1;
          rsp.read_value <= 32'd0;
          rsp.fetch_address <= nf.pc;
          rsp.finished <= fin;
          rsp.stalled <= stall;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/fspc_checker.sv =====
// Port-level checks on the five-stage pipeline core, bound to the top level.
// Depends on the top level's channel ports.
module fspc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_read_value,
  input logic        rsp_finished,
  input logic        rsp_stalled
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
    else $error("response transaction dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("new transaction taken while one is in progress");

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !cmd_ready)
    else $error("command taken while a result waits");

  a_stall_not_finished: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_stalled && rsp_finished))
    else $error("stalled cycle reported as finished");
endmodule

bind five_stage_pipeline_core fspc_checker u_fspc_checker (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_read_value(rsp.read_value),
  .rsp_finished(rsp.finished), .rsp_stalled(rsp.stalled));

// ===== dv/tb_top.sv =====
// Self-checking testbench for five_stage_pipeline_core: loads programs and data,
// runs cycles and reads back state, checking each response against a cycle model.
// Depends on fspc_pkg, fspc_if and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fspc_pkg::*;

  typedef struct {logic [31:0] pc; bit nop;} if_st_t;
  typedef struct {logic [31:0] instr; bit nop;} id_st_t;
  typedef struct {
    logic [31:0] rd1, rd2, imm, rs, rt, wreg;
    bit is_i, rd_mem, wrt_mem, alu_add, wen, nop;
  } ex_st_t;
  typedef struct {
    logic [31:0] alu, store, rs, rt, wreg;
    bit rd_mem, wrt_mem, wen, nop;
  } mm_st_t;
  typedef struct {logic [31:0] data, rs, rt, wreg; bit wen, nop;} wb_st_t;
  typedef struct {
    logic [31:0] read_value, fetch_address;
    logic finished, stalled;
  } core_rsp_t;

  logic clk = 0;
  logic rst = 1;
  fspc_cmd_if cmd_ch();
  fspc_rsp_if rsp_ch();

  five_stage_pipeline_core DUT (.clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch));

  always #1 clk = ~clk;

  logic [31:0] regs_q [32];
  logic [7:0]  imem_q [IMEM_BYTES];
  logic [7:0]  dmem_q [DMEM_BYTES];
  if_st_t fs;
  id_st_t ds;
  ex_st_t es;
  mm_st_t ms;
  wb_st_t ws;

  core_rsp_t pending_rsp[$];
  int errors = 0;
  int sent = 0;
  int hold_cnt = 0;

  function automatic logic [31:0] sx16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [31:0] dword(logic [31:0] a);
    logic [31:0] wd;
    wd = 0;
    for (int i = 0; i < 4; i++) wd = {wd[23:0], dmem_q[DMEM_AW'(a + 32'(i))]};
    return wd;
  endfunction

  function automatic logic [31:0] iword(logic [31:0] a);
    logic [31:0] wd;
    wd = 0;
    for (int i = 0; i < 4; i++) wd = {wd[23:0], imem_q[IMEM_AW'(a + 32'(i))]};
    return wd;
  endfunction

  function automatic bit all_bubbles();
    return fs.nop && ds.nop && es.nop && ms.nop && ws.nop;
  endfunction

  function automatic void advance_pipe(output bit stl, output bit fin);
    if_st_t nf;
    id_st_t nd;
    ex_st_t ne;
    mm_st_t nm;
    wb_st_t nw;
    logic [31:0] a, b, sd, ins;
    logic [5:0] op, fn;
    logic [4:0] rs, rt;
    bit rtw, id_bub, if_idle;
    nf = fs; nd = ds; ne = es; nm = ms; nw = ws;
    stl = 0;
    fin = 0;
    if (!ws.nop && ws.wen) regs_q[ws.wreg[4:0]] = ws.data;
    if (!ms.nop) begin
      if (ms.rd_mem) nw.data = dword(ms.alu);
      else if (ms.wrt_mem) begin
        sd = ms.store;
        if (!ws.nop && ws.wen && ws.wreg == ms.rt) sd = ws.data;
        for (int i = 0; i < 4; i++) dmem_q[DMEM_AW'(ms.alu + 32'(i))] = sd[31 - 8*i -: 8];
        nw.data = sd;
      end else if (ms.wen) nw.data = ms.alu;
      nw.rs = ms.rs; nw.rt = ms.rt; nw.wreg = ms.wreg; nw.wen = ms.wen;
    end
    nw.nop = ms.nop;
    if (!es.nop) begin
      a = es.rd1;
      b = es.rd2;
      rtw = !es.is_i && es.wen;
      if (!ws.nop && ws.wen && ws.wreg == es.rs) a = ws.data;
      if (!ws.nop && ws.wen && ws.wreg == es.rt && (rtw || es.wrt_mem)) b = ws.data;
      if (!ms.nop && ms.wen && ms.wreg == es.rs) a = ms.alu;
      if (!ms.nop && ms.wen && ms.wreg == es.rt && rtw) b = ms.alu;
      if (!es.is_i) nm.alu = es.wen ? (es.alu_add ? a + b : a - b) : 0;
      else nm.alu = a + sx16(es.imm);
      nm.store = b; nm.rs = es.rs; nm.rt = es.rt; nm.wreg = es.wreg;
      nm.rd_mem = es.rd_mem; nm.wrt_mem = es.wrt_mem; nm.wen = es.wen;
    end
    nm.nop = es.nop;
    id_bub = ds.nop;
    if (!ds.nop) begin
      op = ds.instr[31:26];
      rs = ds.instr[25:21];
      rt = ds.instr[20:16];
      ne.rs = 32'(rs); ne.rt = 32'(rt);
      ne.rd1 = regs_q[rs]; ne.rd2 = regs_q[rt];
      ne.imm = {16'd0, ds.instr[15:0]};
      if (op == OP_RTYPE) begin
        fn = ds.instr[5:0];
        ne.wreg = 32'(ds.instr[15:11]);
        ne.is_i = 0; ne.rd_mem = 0; ne.wrt_mem = 0;
        if (fn == FN_ADDU) ne.alu_add = 1;
        else if (fn == FN_SUBU) ne.alu_add = 0;
        ne.wen = 1;
      end else if (op == OP_LW) begin
        ne.wreg = 32'(rt); ne.is_i = 1; ne.rd_mem = 1; ne.wrt_mem = 0;
        ne.alu_add = 1; ne.wen = 1;
      end else if (op == OP_SW) begin
        ne.wreg = 32'(rt); ne.is_i = 1; ne.rd_mem = 0; ne.wrt_mem = 1;
        ne.alu_add = 1; ne.wen = 0;
      end else if (op == OP_BNE) begin
        ne.wreg = 0; ne.is_i = 0; ne.rd_mem = 0; ne.wrt_mem = 0;
        ne.alu_add = 1; ne.wen = 0;
        if (regs_q[rs] != regs_q[rt]) begin
          nf.pc = fs.pc + (sx16(ds.instr) << 2);
          nf.nop = 0;
          nd.nop = 1;
          ne.nop = 0;
          fs = nf; ds = nd; es = ne; ms = nm; ws = nw;
          return;
        end
      end else id_bub = 1;
      if (op == OP_RTYPE && !es.nop && es.rd_mem &&
          (es.wreg == 32'(rs) || es.wreg == 32'(rt))) begin
        ne.nop = 1;
        stl = 1;
        es = ne; ms = nm; ws = nw;
        return;
      end
    end
    ne.nop = id_bub;
    if_idle = fs.nop;
    if (!fs.nop) begin
      ins = iword(fs.pc);
      nd.instr = ins;
      if (ins != HALT_WORD) begin
        nf.pc = fs.pc + 4;
        nf.nop = 0;
      end else begin
        nf.nop = 1;
        if_idle = 1;
      end
    end
    nd.nop = if_idle;
    fin = if_idle && ds.nop && es.nop && ms.nop && ws.nop;
    fs = nf; ds = nd; es = ne; ms = nm; ws = nw;
  endfunction

  function automatic core_rsp_t predict_rsp(logic [2:0] md, logic [9:0] ad, logic [7:0] bv);
    core_rsp_t r;
    bit stl, fin;
    r.read_value = 0;
    stl = 0;
    fin = all_bubbles();
    case (md)
      MODE_LOAD_INSTR: imem_q[IMEM_AW'(ad)] = bv;
      MODE_LOAD_DATA:  dmem_q[DMEM_AW'(ad)] = bv;
      MODE_RUN:        advance_pipe(stl, fin);
      MODE_READ_REG:   r.read_value = regs_q[ad[4:0]];
      MODE_READ_WORD:  r.read_value = dword(32'(ad));
      default: ;
    endcase
    r.fetch_address = fs.pc;
    r.finished = fin;
    r.stalled = stl;
    return r;
  endfunction

  task automatic send_item(logic [2:0] md, logic [9:0] ad, logic [7:0] bv);
    int gap;
    int pk;
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= md;
    cmd_ch.address <= ad;
    cmd_ch.byte_value <= bv;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_rsp.push_back(predict_rsp(md, ad, bv));
    sent++;
    pk = $urandom_range(0, 99);
    gap = (pk < 60) ? 0 : (pk < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_instr(logic [31:0] addr, logic [31:0] ins);
    for (int i = 0; i < 4; i++)
      send_item(MODE_LOAD_INSTR, 10'(addr + 32'(i)), ins[31 - 8*i -: 8]);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] ins;
    logic [5:0] op;
    int r;
    r = $urandom_range(0, 99);
    ins = {6'd0, pick_reg(), pick_reg(), pick_reg(), 5'd0, FN_ADDU};
    if (r >= 25 && r < 40) ins[5:0] = FN_SUBU;
    else if (r >= 40 && r < 75) begin
      ins[31:26] = (r < 60) ? OP_LW : OP_SW;
      ins[15:0] = 16'($urandom);
    end else if (r >= 75 && r < 88) begin
      ins[31:26] = OP_BNE;
      ins[15:0] = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                  16'($signed($urandom_range(0, 6)) - 3);
    end else if (r >= 88 && r < 94) ins[10:0] = 11'($urandom);
    else if (r >= 94) begin
      do op = 6'($urandom); while (op == OP_RTYPE || op == OP_LW || op == OP_SW || op == OP_BNE);
      ins = {op, 26'($urandom)};
      if (ins == HALT_WORD) ins[0] = 1'b0;
    end
    return ins;
  endfunction

  task automatic test_memory_edges();
    send_item(MODE_LOAD_DATA, 10'd1022, 8'hFF);
    send_item(MODE_LOAD_DATA, 10'd1023, 8'h00);
    send_item(MODE_LOAD_DATA, 10'd0, 8'hA5);
    send_item(MODE_LOAD_DATA, 10'd1, 8'h5A);
    send_item(MODE_READ_WORD, 10'd1022, 8'hFF);
    send_item(MODE_READ_WORD, 10'd1023, 8'h00);
    send_item(MODE_READ_REG, 10'h3FF, 8'hFF);
    send_item(MODE_READ_REG, 10'h000, 8'h00);
  endtask

  task automatic test_unused_modes();
    send_item(3'd5, 10'h3FF, 8'hFF);
    send_item(3'd6, 10'h155, 8'hAA);
    send_item(3'd7, 10'h2AA, 8'h55);
  endtask

  task automatic test_zero_program();
    repeat (4) send_item(MODE_RUN, 10'($urandom), 8'($urandom));
  endtask

  task automatic test_random_programs();
    logic [31:0] base;
    int k;
    int pk;
    while (sent < 380) begin
      base = fs.pc;
      k = $urandom_range(3, 8);
      for (int i = 0; i < k; i++) put_instr(base + 4*i, random_instr());
      repeat ($urandom_range(1, 3)) send_item(MODE_LOAD_DATA, 10'($urandom), 8'($urandom));
      repeat (k + 4) begin
        pk = $urandom_range(0, 99);
        if (pk < 8) send_item(MODE_READ_REG, 10'($urandom), 8'($urandom));
        else if (pk < 14) send_item(MODE_READ_WORD, 10'($urandom), 8'($urandom));
        else if (pk < 16) send_item(3'($urandom_range(5, 7)), 10'($urandom), 8'($urandom));
        send_item(MODE_RUN, 10'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_halt_and_drain();
    int n;
    put_instr(fs.pc, HALT_WORD);
    n = 0;
    while (!all_bubbles() && n < 40) begin
      send_item(MODE_RUN, 10'($urandom), 8'($urandom));
      n++;
    end
    repeat (3) send_item(MODE_RUN, 10'($urandom), 8'($urandom));
    for (int i = 0; i < 32; i++) send_item(MODE_READ_REG, 10'(i), 8'($urandom));
  endtask

  always @(posedge clk) begin
    int pk;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      pk = $urandom_range(0, 99);
      rsp_ch.ready <= (pk < 70);
      if (pk >= 70) hold_cnt <= (pk < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    core_rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, actual read_value %h", $realtime,
                 rsp_ch.read_value);
      end else begin
        exp_r = pending_rsp.pop_front();
        if (rsp_ch.read_value !== exp_r.read_value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $realtime,
                   exp_r.read_value, rsp_ch.read_value);
        end
        if (rsp_ch.fetch_address !== exp_r.fetch_address) begin
          errors++;
          $display("%0t: fetch_address expected %h actual %h", $realtime,
                   exp_r.fetch_address, rsp_ch.fetch_address);
        end
        if (rsp_ch.finished !== exp_r.finished) begin
          errors++;
          $display("%0t: finished expected %b actual %b", $realtime,
                   exp_r.finished, rsp_ch.finished);
        end
        if (rsp_ch.stalled !== exp_r.stalled) begin
          errors++;
          $display("%0t: stalled expected %b actual %b", $realtime,
                   exp_r.stalled, rsp_ch.stalled);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) regs_q[i] = 0;
    for (int i = 0; i < IMEM_BYTES; i++) imem_q[i] = 0;
    for (int i = 0; i < DMEM_BYTES; i++) dmem_q[i] = 0;
    fs = '{pc: 0, nop: 0};
    ds = '{instr: 0, nop: 1};
    es = '{default: 0};
    es.nop = 1;
    ms = '{default: 0};
    ms.nop = 1;
    ws = '{default: 0};
    ws.nop = 1;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = '0;
    cmd_ch.address = '0;
    cmd_ch.byte_value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_memory_edges();
    test_unused_modes();
    test_zero_program();
    test_random_programs();
    test_halt_and_drain();
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
